@@ src/assert_macros.svh @@
// assertion macros shared by the framer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("framer assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("framer forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

@@ src/sbf_pkg.sv @@
// types and constants of the sample block framer
package sbf_pkg;

  // input commands
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_CONT   = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_ARG   = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [1:0] ST_ORDER     = 2'd3;

  // register indexes
  localparam logic CFG_LEN_FIELD  = 1'b0;
  localparam logic CFG_SAMPLE_DBL = 1'b1;

  // register reset values
  localparam logic [7:0] LEN_FIELD_RESET  = 8'd2;
  localparam logic       SAMPLE_DBL_RESET = 1'b1;

  // control byte pieces
  localparam logic [7:0] CTRL_START = 8'h06;
  localparam logic [7:0] CTRL_CONT  = 8'h05;
  localparam logic [7:0] CTRL_MULTI = 8'h80;

  // largest payload for a 2-byte length field
  localparam logic [35:0] MAX_LEN16 = 36'h0_0000_FFFF;

  // byte image of the longest item
  localparam int IMG_BYTES = 27;
  localparam int IMG_W     = IMG_BYTES * 8;
  localparam int CNT_W     = 5;

  // one queued word group: bytes to send, lowest first
  typedef struct packed {
    logic [IMG_W-1:0] image;
    logic [CNT_W-1:0] nbytes;
    logic             frame_last;
    logic [1:0]       status;
  } job_t;

endpackage

@@ src/sample_block_framer_core.sv @@
// sample block framer top level: front end, queue and byte serializer
// an accepted item is written into the queue, then loaded into the byte serializer
// throughput: one output byte per cycle while m_tready is high, from the byte image shift register;
//   a header gives 5 to 27 bytes, a sample 4 or 8, an error item one byte
// input items are taken each cycle while the image queue has room
// reset (rst, synchronous): no frame open, queue empty, registers to defaults
module sample_block_framer_core
  import sbf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  // configuration writes
  input  logic         cfg_wr_en,
  input  logic         cfg_index,
  input  logic [7:0]   cfg_data,
  // input items
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [239:0] s_tdata,  // channel, sample_count, start_time_ns, rate_bits, sample_bits
  input  logic [1:0]   s_tuser,  // cmd
  // output bytes
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata,  // out_byte
  output logic         m_tlast,  // item_last
  output logic [2:0]   m_tuser   // frame_last, status
);

  logic accept;
  logic full;
  logic empty;
  logic pop;
  job_t push_job;
  job_t head;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  // classify and build images
  sbf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .cmd           (s_tuser),
    .channel       (s_tdata[15:0]),
    .sample_count  (s_tdata[47:16]),
    .start_time_ns (s_tdata[111:48]),
    .rate_bits     (s_tdata[175:112]),
    .sample_bits   (s_tdata[239:176]),
    .job           (push_job)
  );

  // decoupling queue
  sbf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  // byte serializer
  sbf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

@@ src/sbf_front.sv @@
// front end: classifies items, tracks the open frame, builds byte images
module sbf_front
  import sbf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic         cfg_index,
  input  logic [7:0]   cfg_data,
  input  logic         accept,
  input  logic [1:0]   cmd,
  input  logic [15:0]  channel,
  input  logic [31:0]  sample_count,
  input  logic [63:0]  start_time_ns,
  input  logic [63:0]  rate_bits,
  input  logic [63:0]  sample_bits,
  output job_t         job
);

  logic [7:0]  length_field_bytes;
  logic        sample_is_double;
  logic        frame_open;
  logic        frame_open_next;
  logic [31:0] samples_left;
  logic [31:0] samples_left_next;
  logic        frame_dbl;
  logic        frame_dbl_next;

  logic          is_hdr;
  logic          start;
  logic          multi;
  logic          lfb2;
  logic          lfb4;
  logic [35:0]   payload;
  logic [35:0]   sample_bytes;
  logic          too_large;
  logic [7:0]    ctrl;
  logic [159:0]  tail;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      length_field_bytes <= LEN_FIELD_RESET;
      sample_is_double   <= SAMPLE_DBL_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LEN_FIELD:  length_field_bytes <= cfg_data;
        CFG_SAMPLE_DBL: sample_is_double   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // header decode and payload length
  always_comb begin
    is_hdr       = (cmd == CMD_START) || (cmd == CMD_CONT);
    start        = (cmd == CMD_START);
    multi        = (sample_count > 32'd1);
    lfb2         = (length_field_bytes == 8'd2);
    lfb4         = (length_field_bytes == 8'd4);
    sample_bytes = sample_is_double ? {1'b0, sample_count, 3'b000}
                                    : {2'b00, sample_count, 2'b00};
    payload      = 36'd1 + (start ? 36'd16 : 36'd0) + (multi ? 36'd4 : 36'd0)
                   + sample_bytes;
    too_large    = lfb4 ? (payload[35:32] != 4'd0) : (payload > MAX_LEN16);
    ctrl         = (start ? CTRL_START : CTRL_CONT) | (multi ? CTRL_MULTI : 8'h00);
    if (start) begin
      tail = {(multi ? sample_count : 32'd0), rate_bits, start_time_ns};
    end else begin
      tail = {128'd0, (multi ? sample_count : 32'd0)};
    end
  end

  // classification and next frame state
  always_comb begin
    job.image         = '0;
    job.nbytes        = CNT_W'(1);
    job.frame_last    = 1'b0;
    job.status        = ST_OK;
    frame_open_next   = frame_open;
    samples_left_next = samples_left;
    frame_dbl_next    = frame_dbl;
    if (is_hdr) begin
      if (frame_open) begin
        job.status = ST_ORDER;
      end else if (sample_count == 32'd0 || !(lfb2 || lfb4)) begin
        job.status = ST_BAD_ARG;
      end else if (too_large) begin
        job.status = ST_TOO_LARGE;
      end else begin
        if (lfb4) begin
          job.image = {tail, ctrl, payload[31:0], channel};
        end else begin
          job.image = {16'd0, tail, ctrl, payload[15:0], channel};
        end
        job.nbytes = CNT_W'(5) + (lfb4 ? CNT_W'(2) : CNT_W'(0))
                   + (start ? CNT_W'(16) : CNT_W'(0))
                   + (multi ? CNT_W'(4) : CNT_W'(0));
        frame_open_next   = 1'b1;
        samples_left_next = sample_count;
        frame_dbl_next    = sample_is_double;
      end
    end else if (cmd == CMD_SAMPLE && frame_open) begin
      job.image         = {{(IMG_W-64){1'b0}}, sample_bits};
      job.nbytes        = frame_dbl ? CNT_W'(8) : CNT_W'(4);
      job.frame_last    = (samples_left == 32'd1);
      samples_left_next = samples_left - 32'd1;
      frame_open_next   = (samples_left != 32'd1);
    end else begin
      job.status = ST_ORDER;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open   <= 1'b0;
      samples_left <= 32'd0;
      frame_dbl    <= 1'b1;
    end else if (accept) begin
      frame_open   <= frame_open_next;
      samples_left <= samples_left_next;
      frame_dbl    <= frame_dbl_next;
    end
  end

endmodule

@@ src/sbf_fifo.sv @@
// short queue of byte images between front and back
module sbf_fifo
  import sbf_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

`include "assert_macros.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == CW'(0));
  assign head  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `ASSERT_NEVER(a_fifo_overfill, clk, rst, count > CW'(DEPTH))
  `ASSERT_NEVER(a_fifo_pop_empty, clk, rst, pop && empty)
  `ASSERT_CLK(a_fifo_grow, clk, rst, (push && !pop) |=> (count == $past(count) + CW'(1)))

endmodule

@@ src/sbf_back.sv @@
// back end: shifts byte images out one byte per cycle while m_tready is high
module sbf_back
  import sbf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  job_t       head,
  input  logic       empty,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast,
  output logic [2:0] m_tuser
);

`include "assert_macros.svh"

  logic             busy;
  logic [IMG_W-1:0] image;
  logic [CNT_W-1:0] cnt;
  logic             frame_last;
  logic [1:0]       status;
  logic             last_byte;
  logic             free;

  assign last_byte = (cnt == CNT_W'(1));
  assign free      = !busy || (m_tready && last_byte);
  assign pop       = free && !empty;

  assign m_tvalid = busy;
  assign m_tdata  = image[7:0];
  assign m_tlast  = last_byte;
  assign m_tuser  = {status, frame_last && last_byte};

  // control: load from queue, advance one byte, or go idle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      cnt  <= head.nbytes;
    end else if (free) begin
      busy <= 1'b0;
    end else if (m_tready) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // byte image shift register
  always_ff @(posedge clk) begin
    if (pop) begin
      image      <= head.image;
      frame_last <= head.frame_last;
      status     <= head.status;
    end else if (busy && m_tready) begin
      image <= image >> 8;
    end
  end

  `ASSERT_CLK(a_back_cnt_live, clk, rst, busy |-> (cnt != CNT_W'(0)))
  `ASSERT_CLK(a_back_step, clk, rst,
    (busy && m_tready && !last_byte) |=> (busy && cnt == $past(cnt) - CNT_W'(1)))
  `ASSERT_CLK(a_back_frame_end, clk, rst, (m_tvalid && m_tuser[0]) |-> m_tlast)

endmodule

@@ verif/sample_block_framer_core_tb.sv @@
// testbench for sample_block_framer_core: directed table, random frames, byte-level checks
module sample_block_framer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sbf_pkg::*;

  // cmd value the block treats as out of order
  localparam logic [1:0] CMD_BAD = 2'd3;
  localparam int RANDOM_ITEMS = 236;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 1000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       item_last;
    logic       frame_last;
    logic [1:0] status;
  } frame_byte_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  cmd;
    logic [15:0] channel;
    logic [31:0] count;
    logic [63:0] start_ns;
    logic [63:0] rate;
    logic [63:0] sample;
    logic        err_known;
    logic [1:0]  err_status;
    logic [7:0]  cfg_len;
    logic        cfg_dbl;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_wr_en = 1'b0;
  logic         cfg_index = 1'b0;
  logic [7:0]   cfg_data = 8'd0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [239:0] s_tdata = '0;  // channel, sample_count, start_time_ns, rate_bits, sample_bits
  logic [1:0]   s_tuser = '0;  // cmd
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [7:0]   m_tdata;       // out_byte
  logic         m_tlast;       // item_last
  logic [2:0]   m_tuser;       // frame_last, status

  // bytes still owed by the block, oldest first
  frame_byte_t pending_bytes[$];
  // directed stimulus table
  stim_row_t   directed_rows[$];
  // framer model state
  logic [7:0]  len_field_sz = LEN_FIELD_RESET;
  logic        dbl_samples  = SAMPLE_DBL_RESET;
  logic        open_frame   = 1'b0;
  logic [31:0] left_samples = '0;
  int          latched_bytes = 8;

  int mismatches = 0;
  int items_sent = 0;
  int stall_cycles = 0;
  logic steady = 1'b0;

  sample_block_framer_core DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  // output back-pressure
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= 16);
  end

  // little-endian bytes of a value into the expected stream
  function automatic void append_le(input logic [63:0] v, input int n);
    frame_byte_t b;
    for (int i = 0; i < n; i++) begin
      b = '{data: v[8*i +: 8], item_last: 1'b0, frame_last: 1'b0, status: ST_OK};
      pending_bytes = {pending_bytes, b};
    end
  endfunction

  // flag the newest expected byte as end of item, optionally end of frame
  function automatic void close_item(input logic end_frame);
    frame_byte_t b;
    b = pending_bytes.pop_back();
    b.item_last = 1'b1;
    b.frame_last = end_frame;
    pending_bytes = {pending_bytes, b};
  endfunction

  function automatic void push_error(input logic [1:0] st);
    frame_byte_t b;
    b = '{data: 8'd0, item_last: 1'b1, frame_last: 1'b0, status: st};
    pending_bytes = {pending_bytes, b};
  endfunction

  // expected bytes and state update for one accepted item
  function automatic void frame_encode(input logic [1:0] cmd, input logic [15:0] channel,
                                       input logic [31:0] count, input logic [63:0] start_ns,
                                       input logic [63:0] rate, input logic [63:0] sample);
    logic        start;
    logic        multi;
    int          ssize;
    logic [63:0] payload;
    logic [63:0] payload_limit;
    start = (cmd == CMD_START);
    multi = (count > 32'd1);
    ssize = dbl_samples ? 8 : 4;
    if (cmd == CMD_START || cmd == CMD_CONT) begin
      // header checks in priority order
      if (open_frame) begin
        push_error(ST_ORDER);
      end else if (count == 32'd0) begin
        push_error(ST_BAD_ARG);
      end else if (len_field_sz != 8'd2 && len_field_sz != 8'd4) begin
        push_error(ST_BAD_ARG);
      end else begin
        payload = 64'd1 + (start ? 64'd16 : 64'd0) + (multi ? 64'd4 : 64'd0)
                + 64'(count) * 64'(ssize);
        payload_limit = (len_field_sz == 8'd2) ? 64'h0000_FFFF : 64'hFFFF_FFFF;
        if (payload > payload_limit) begin
          push_error(ST_TOO_LARGE);
        end else begin
          append_le(64'(channel), 2);
          append_le(payload, int'(len_field_sz));
          append_le(64'((start ? CTRL_START : CTRL_CONT) | (multi ? CTRL_MULTI : 8'h00)), 1);
          if (start) begin
            append_le(start_ns, 8);
            append_le(rate, 8);
          end
          if (multi) append_le(64'(count), 4);
          close_item(1'b0);
          open_frame = 1'b1;
          left_samples = count;
          latched_bytes = ssize;
        end
      end
    end else if (cmd == CMD_SAMPLE && open_frame) begin
      append_le(sample, latched_bytes);
      left_samples = left_samples - 32'd1;
      if (left_samples == 32'd0) open_frame = 1'b0;
      close_item(!open_frame);
    end else begin
      push_error(ST_ORDER);
    end
  endfunction

  // present one word and wait for it to be taken
  task automatic send_word(input logic [1:0] cmd, input logic [15:0] channel,
                           input logic [31:0] count, input logic [63:0] start_ns,
                           input logic [63:0] rate, input logic [63:0] sample,
                           input logic err_known, input logic [1:0] err_status);
    if (!steady) begin
      while ($urandom_range(0, 99) < 16) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {sample, rate, start_ns, count, channel};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (err_known) push_error(err_status);
    else frame_encode(cmd, channel, count, start_ns, rate, sample);
    items_sent++;
  endtask

  // stop sending and let every owed byte drain
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [7:0] len, input logic dbl);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_LEN_FIELD;
    cfg_data <= len;
    @(posedge clk);
    cfg_index <= CFG_SAMPLE_DBL;
    cfg_data <= {7'd0, dbl};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    len_field_sz = len;
    dbl_samples = dbl;
  endtask

  // new register setting, mostly legal length sizes
  task automatic reconfig();
    int r;
    logic [7:0] len;
    r = $urandom_range(0, 99);
    if (r < 45) len = 8'd2;
    else if (r < 90) len = 8'd4;
    else len = 8'($urandom_range(0, 255));
    settle();
    write_cfg(len, 1'($urandom_range(0, 1)));
  endtask

  // noise word: header with a zero count or a count that can never fit, sample, or bad cmd
  task automatic send_noise();
    logic [1:0]  cmd;
    logic [31:0] count;
    cmd = 2'($urandom_range(0, 3));
    count = $urandom_range(0, 1) ? 32'd0 : ($urandom | 32'h8000_0000);
    send_word(cmd, 16'($urandom), count, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, 1'b0, ST_OK);
  endtask

  // one header followed by its samples, with occasional disturbance
  task automatic random_frame();
    int r;
    logic [1:0]  hcmd;
    logic [31:0] count;
    hcmd = $urandom_range(0, 1) ? CMD_START : CMD_CONT;
    r = $urandom_range(0, 99);
    if (r < 5) count = 32'd0;
    else if (r < 15) count = $urandom | 32'h4000_0000;
    else if (r < 22) count = 32'($urandom_range(7, 40));
    else count = 32'($urandom_range(1, 6));
    send_word(hcmd, 16'($urandom), count, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, 1'b0, ST_OK);
    while (open_frame) begin
      r = $urandom_range(0, 99);
      if (r < 4) send_noise();
      else if (r < 6) reconfig();
      else send_word(CMD_SAMPLE, 16'($urandom), $urandom, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom}, 1'b0, ST_OK);
    end
  endtask

  function automatic stim_row_t row_item(input logic [1:0] cmd, input logic [15:0] channel,
                                         input logic [31:0] count, input logic [63:0] start_ns,
                                         input logic [63:0] rate, input logic [63:0] sample);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.cmd = cmd;
    row.channel = channel;
    row.count = count;
    row.start_ns = start_ns;
    row.rate = rate;
    row.sample = sample;
    return row;
  endfunction

  function automatic stim_row_t row_err(input logic [1:0] cmd, input logic [31:0] count,
                                        input logic [1:0] st);
    stim_row_t row;
    row = row_item(cmd, 16'hA5A5, count, 64'h1, 64'h2, 64'h3);
    row.err_known = 1'b1;
    row.err_status = st;
    return row;
  endfunction

  function automatic stim_row_t row_cfg(input logic [7:0] len, input logic dbl);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.cfg_len = len;
    row.cfg_dbl = dbl;
    return row;
  endfunction

  // append one row to the directed table
  function automatic void add_row(input stim_row_t r);
    directed_rows = {directed_rows, r};
  endfunction

  // compare each delivered byte with the oldest expectation
  always @(posedge clk) begin : check_bytes
    frame_byte_t want;
    frame_byte_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = '{data: m_tdata, item_last: m_tlast, frame_last: m_tuser[0],
              status: m_tuser[2:1]};
      if (pending_bytes.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("unexpected word: byte %h item_last %b frame_last %b status %0d",
                   got.data, got.item_last, got.frame_last, got.status);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        if (got !== want) begin
          if (mismatches < REPORT_MAX)
            $display("mismatch: want %h il %b fl %b st %0d, got %h il %b fl %b st %0d",
                     want.data, want.item_last, want.frame_last, want.status,
                     got.data, got.item_last, got.frame_last, got.status);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on any side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("sample_block_framer_core_tb failed");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    int random_start;

    // defaults after reset: 2-byte length field, double samples
    add_row(row_err(CMD_SAMPLE, 32'd1, ST_ORDER));
    add_row(row_err(CMD_BAD, 32'd1, ST_ORDER));
    add_row(row_err(CMD_START, 32'd0, ST_BAD_ARG));
    add_row(row_err(CMD_CONT, 32'd0, ST_BAD_ARG));
    add_row(row_item(CMD_START, 16'hFFFF, 32'd1, 64'h8000_0000_0000_0000,
                     64'hFFFF_FFFF_FFFF_FFFF, 64'h0));
    add_row(row_item(CMD_SAMPLE, 16'h0, 32'd0, 64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF));
    add_row(row_item(CMD_CONT, 16'h0, 32'd3, 64'h0, 64'h0, 64'h0));
    // header while a frame is open
    add_row(row_err(CMD_START, 32'd1, ST_ORDER));
    add_row(row_err(CMD_CONT, 32'd1, ST_ORDER));
    add_row(row_item(CMD_SAMPLE, 16'h0, 32'd0, 64'h0, 64'h0, 64'h0));
    add_row(row_item(CMD_SAMPLE, 16'h0, 32'd0, 64'h0, 64'h0, 64'h0123_4567_89AB_CDEF));
    add_row(row_item(CMD_SAMPLE, 16'h0, 32'd0, 64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF));
    // payload just over and far over the 2-byte field
    add_row(row_err(CMD_START, 32'd8190, ST_TOO_LARGE));
    add_row(row_err(CMD_START, 32'hFFFF_FFFF, ST_TOO_LARGE));
    add_row(row_cfg(8'd4, 1'b1));
    add_row(row_err(CMD_START, 32'hFFFF_FFFF, ST_TOO_LARGE));
    add_row(row_item(CMD_START, 16'h8001, 32'd2, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0, 64'h0));
    // sample size change mid-frame only applies at the next header
    add_row(row_cfg(8'd4, 1'b0));
    add_row(row_item(CMD_SAMPLE, 16'h0, 32'd0, 64'h0, 64'h0, 64'hDEAD_BEEF_CAFE_F00D));
    add_row(row_item(CMD_SAMPLE, 16'h0, 32'd0, 64'h0, 64'h0, 64'h5555_AAAA_5555_AAAA));
    // illegal length field sizes
    add_row(row_cfg(8'd0, 1'b0));
    add_row(row_err(CMD_CONT, 32'd1, ST_BAD_ARG));
    add_row(row_cfg(8'd255, 1'b0));
    add_row(row_err(CMD_START, 32'd2, ST_BAD_ARG));
    add_row(row_cfg(8'd2, 1'b0));
    add_row(row_err(CMD_START, 32'd16379, ST_TOO_LARGE));
    // float sample only sends its low half
    add_row(row_item(CMD_CONT, 16'h1234, 32'd1, 64'h0, 64'h0, 64'h0));
    add_row(row_item(CMD_SAMPLE, 16'h0, 32'd0, 64'h0, 64'h0, 64'hFFFF_FFFF_3F80_0000));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        settle();
        write_cfg(row.cfg_len, row.cfg_dbl);
      end else begin
        send_word(row.cmd, row.channel, row.count, row.start_ns, row.rate, row.sample,
                  row.err_known, row.err_status);
      end
    end

    // random frames with noise and register changes
    random_start = items_sent;
    while (items_sent < random_start + RANDOM_ITEMS) begin
      steady = (items_sent >= random_start + 100) && (items_sent < random_start + 160);
      if ($urandom_range(0, 9) == 0) reconfig();
      if ($urandom_range(0, 99) < 12) send_noise();
      else random_frame();
    end
    steady = 1'b0;

    settle();
    if (mismatches == 0)
      $display("sample_block_framer_core_tb passed");
    else
      $display("sample_block_framer_core_tb failed");
    $finish;
  end

endmodule
